FILE: rtl/spq_pkg.sv
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int PRIO_W        = 32;
    localparam int COUNT_FIELD_W = 5;
    localparam int STATUS_W      = 2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] item_data;
        logic signed [PRIO_W-1:0] item_priority;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  out_data;
        logic [STATUS_W-1:0]       status;
        logic                      now_empty;
        logic [COUNT_FIELD_W-1:0]  entry_count;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic enq;
        logic deq;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

FILE: rtl/spq_ctrl.sv
// Handshake controller for the sorted priority queue.
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               req_kind,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A held result that is being taken frees the output register this cycle.
    assign req_stall = (state_reg == ST_HOLD) && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = (state_reg == ST_HOLD);

    always_comb
    begin
        cmd.load = accept;
        cmd.enq  = accept && (req_kind == spq_pkg::KIND_ENQ) && !stat.full;
        cmd.deq  = accept && (req_kind == spq_pkg::KIND_DEQ) && !stat.empty;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (accept)
                    state_next = ST_HOLD;
                else if (!rsp_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/spq_datapath.sv
// Compare-and-shift entry array, count and result register of the priority queue.
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::req_item_t  req,
    input  spq_pkg::spq_cmd_t   cmd,
    output spq_pkg::spq_stat_t  stat,
    output spq_pkg::rsp_item_t  rsp,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [spq_pkg::DATA_W-1:0] data_reg [DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg [DEPTH];
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [DEPTH-1:0]                  ge;
    spq_pkg::rsp_item_t                rsp_reg;
    spq_pkg::rsp_item_t                rsp_next;
    logic [CNT_W+spq_pkg::COUNT_FIELD_W-1:0] count_wide;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign count      = count_reg;
    assign rsp        = rsp_reg;

    // Held entries are sorted, so the set of cells that stay in front of a
    // new entry is always a prefix of the array.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            ge[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] >= req.item_priority);
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                              front_ge;
        logic signed [spq_pkg::DATA_W-1:0] below_data;
        logic signed [spq_pkg::PRIO_W-1:0] below_prio;
        logic signed [spq_pkg::DATA_W-1:0] above_data;
        logic signed [spq_pkg::PRIO_W-1:0] above_prio;

        if (g == 0)
        begin : g_head
            assign front_ge   = 1'b1;
            assign above_data = req.item_data;
            assign above_prio = req.item_priority;
        end
        else
        begin : g_body
            assign front_ge   = ge[g-1];
            assign above_data = data_reg[g-1];
            assign above_prio = prio_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign below_data = data_reg[g];
            assign below_prio = prio_reg[g];
        end
        else
        begin : g_mid
            assign below_data = data_reg[g+1];
            assign below_prio = prio_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.enq && !ge[g])
            begin
                if (front_ge)
                begin
                    data_reg[g] <= req.item_data;
                    prio_reg[g] <= req.item_priority;
                end
                else
                begin
                    data_reg[g] <= above_data;
                    prio_reg[g] <= above_prio;
                end
            end
            else if (cmd.deq)
            begin
                data_reg[g] <= below_data;
                prio_reg[g] <= below_prio;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.deq)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        count_wide           = {{spq_pkg::COUNT_FIELD_W{1'b0}}, count_next};
        rsp_next.out_data    = cmd.deq ? data_reg[0] : '0;
        rsp_next.status      = spq_pkg::STATUS_OK;
        if (req.kind == spq_pkg::KIND_ENQ && stat.full)
            rsp_next.status = spq_pkg::STATUS_FULL;
        else if (req.kind == spq_pkg::KIND_DEQ && stat.empty)
            rsp_next.status = spq_pkg::STATUS_EMPTY;
        rsp_next.now_empty   = (count_next == '0);
        rsp_next.entry_count = count_wide[spq_pkg::COUNT_FIELD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

FILE: rtl/sorted_priority_queue_core.sv
// Sorted priority queue: DEPTH entries kept highest priority first.
//
// Request channel (req_valid, req_stall, req): kind selects enqueue or
// dequeue. An enqueue stores item_data behind every held entry whose
// priority is greater than or equal to item_priority; a dequeue removes
// the front entry. Response channel (rsp_valid, rsp_stall, rsp): exactly
// one item per request, with the dequeued data (zero otherwise), a status
// (ok, empty on a dequeue of an empty queue, full on a dropped enqueue),
// the empty flag and the entry count after the operation.
// The response is valid in the cycle after the request is accepted. One
// request per cycle is sustained while the receiver does not stall; every
// cell compares and shifts in parallel, so the whole entry array is
// updated together.
// When the receiver stalls, the held response stays put and req_stall is
// raised; a request is taken in the same cycle the held response leaves.
// Reset empties the queue and clears any held response; no sweep of the
// entry array is needed.
module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  spq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spq_pkg::rsp_item_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    spq_pkg::spq_cmd_t  cmd;
    spq_pkg::spq_stat_t stat;
    logic [CNT_W-1:0]   count;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_kind  (req.kind),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp),
        .count (count)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |=> count == $past(count) + CNT_W'(1))
        else $error("accepted enqueue did not add an entry");

    a_no_enq_deq: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.enq && cmd.deq))
        else $error("enqueue and dequeue commanded together");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == spq_pkg::STATUS_EMPTY |-> rsp.now_empty
            && rsp.out_data == '0)
        else $error("empty status with entries or data reported");
`endif

endmodule
